### design/dmc_pkg.sv
// Shared constants, codes and types for the direct-mapped write-back cache.
package dmc_pkg;

    // Geometry of the cache and the backing memory (powers of two).
    localparam int NUM_LINES      = 128;
    localparam int WORDS_PER_LINE = 16;
    localparam int MEM_WORDS      = 65536;

    localparam int IDX_W       = $clog2(NUM_LINES);
    localparam int OFF_W       = $clog2(WORDS_PER_LINE);
    localparam int WORD_W      = $clog2(MEM_WORDS);
    localparam int TAG_W       = WORD_W - IDX_W - OFF_W;
    localparam int LINE_ADDR_W = IDX_W + OFF_W;
    localparam int LINE_WORDS  = NUM_LINES * WORDS_PER_LINE;

    // Field widths of the transaction payloads.
    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 18;
    localparam int DATA_W     = 32;
    localparam int OUTCOME_W  = 3;
    localparam int COST_W     = 16;
    localparam int TOTAL_W    = 32;

    // Configuration registers.
    localparam int HIT_COST_W   = 8;
    localparam int MISS_PEN_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [HIT_COST_W-1:0] HIT_COST_RESET     = HIT_COST_W'(1);
    localparam logic [MISS_PEN_W-1:0] MISS_PENALTY_RESET = MISS_PEN_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIT_COST     = 1'b0,
        CFG_MISS_PENALTY = 1'b1
    } cfg_index_t;

    // Function codes: bit one set means a preload of the backing memory.
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = FUNC_W'(1);
    localparam int                PRELOAD_BIT = 1;

    // Outcome codes reported with each result.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT     = 3'd0,
        OUT_COLD    = 3'd1,
        OUT_CLEAN   = 3'd2,
        OUT_DIRTY   = 3'd3,
        OUT_PRELOAD = 3'd4
    } outcome_t;

    // One entry of the tag store.
    typedef struct packed {
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } tag_entry_t;

    // Write request into the tag store; a write also marks the line valid.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        tag_entry_t       entry;
    } tag_wr_t;

    // Registered lookup result from the tag store.
    typedef struct packed {
        logic       valid;
        tag_entry_t entry;
    } tag_rd_t;

endpackage

### design/dmc_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module dmc_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/dmc_tag_store.sv
// Tag and dirty memory with per-line valid flops cleared at reset.
module dmc_tag_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dmc_pkg::IDX_W-1:0]   rd_index,
    input  dmc_pkg::tag_wr_t            wr,
    output dmc_pkg::tag_rd_t            rd
);
    import dmc_pkg::*;

    tag_entry_t           tag_mem [NUM_LINES];
    tag_entry_t           rd_entry_reg;
    logic [NUM_LINES-1:0] valid_reg;
    logic                 rd_valid_reg;

    // Tag memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tag_mem[wr.index] <= wr.entry;
        end
        rd_entry_reg <= tag_mem[rd_index];
    end

    // Valid bits live in flops so that reset invalidates every line at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.index] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_index];
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.entry = rd_entry_reg;

endmodule

### design/dmc_ctrl.sv
// Access sequencer: lookup, victim writeback, line refill, statistics and result register.
module dmc_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port.
    input  logic                              cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Request channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dmc_pkg::FUNC_W-1:0]        func,
    input  logic [dmc_pkg::ADDR_W-1:0]        byte_address,
    input  logic [dmc_pkg::DATA_W-1:0]        write_data,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dmc_pkg::DATA_W-1:0]        read_data,
    output logic                              hit,
    output logic [dmc_pkg::OUTCOME_W-1:0]     outcome,
    output logic [dmc_pkg::COST_W-1:0]        access_cycles,
    output logic [dmc_pkg::TOTAL_W-1:0]       hits_so_far,
    output logic [dmc_pkg::TOTAL_W-1:0]       misses_so_far,
    output logic [dmc_pkg::TOTAL_W-1:0]       cycles_so_far,
    // Tag store.
    output logic [dmc_pkg::IDX_W-1:0]         tag_rd_index,
    output dmc_pkg::tag_wr_t                  tag_wr,
    input  dmc_pkg::tag_rd_t                  tag_rd,
    // Line word memory.
    output logic                              line_we,
    output logic [dmc_pkg::LINE_ADDR_W-1:0]   line_waddr,
    output logic [dmc_pkg::DATA_W-1:0]        line_wdata,
    output logic [dmc_pkg::LINE_ADDR_W-1:0]   line_raddr,
    input  logic [dmc_pkg::DATA_W-1:0]        line_rdata,
    // Backing memory.
    output logic                              back_we,
    output logic [dmc_pkg::WORD_W-1:0]        back_waddr,
    output logic [dmc_pkg::DATA_W-1:0]        back_wdata,
    output logic [dmc_pkg::WORD_W-1:0]        back_raddr,
    input  logic [dmc_pkg::DATA_W-1:0]        back_rdata
);
    import dmc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_WB,
        S_FILL,
        S_RESP
    } state_t;

    localparam logic [OFF_W:0] CNT_ONE  = (OFF_W + 1)'(1);
    localparam logic [OFF_W:0] CNT_LAST = (OFF_W + 1)'(WORDS_PER_LINE);

    state_t               state_reg;
    logic [WORD_W-1:0]    clr_cnt_reg;
    logic [OFF_W:0]       cnt_reg;
    logic [WORD_W-1:0]    req_word_reg;
    logic [DATA_W-1:0]    req_data_reg;
    logic                 req_write_reg;
    logic                 req_preload_reg;
    logic [TAG_W-1:0]     old_tag_reg;
    logic [DATA_W-1:0]    rdata_reg;
    outcome_t             outcome_reg;
    logic [HIT_COST_W-1:0] hit_cost_reg;
    logic [MISS_PEN_W-1:0] miss_penalty_reg;
    logic [TOTAL_W-1:0]   hits_reg;
    logic [TOTAL_W-1:0]   misses_reg;
    logic [TOTAL_W-1:0]   cycles_reg;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic                 out_hit_reg;
    outcome_t             out_outcome_reg;
    logic [COST_W-1:0]    out_cost_reg;

    logic [WORD_W-1:0]    in_word;
    logic                 in_accept;
    logic                 in_preload;
    logic [IDX_W-1:0]     req_index;
    logic [OFF_W-1:0]     req_off;
    logic [TAG_W-1:0]     req_tag;
    logic [OFF_W:0]       cnt_prev;
    logic [OFF_W-1:0]     cnt_lo;
    logic [OFF_W-1:0]     cnt_prev_lo;
    logic                 lookup_hit;
    logic                 out_load;
    logic                 resp_hit;
    logic [COST_W-1:0]    resp_cost;
    logic [TOTAL_W-1:0]   hits_inc;
    logic [TOTAL_W-1:0]   misses_inc;
    logic [TOTAL_W:0]     cycles_sum;
    logic [TOTAL_W-1:0]   cycles_add;

    // Address split of the incoming and the held request.
    assign in_word     = byte_address[WORD_W+1:2];
    assign in_preload  = func[PRELOAD_BIT];
    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign req_off     = req_word_reg[OFF_W-1:0];
    assign req_index   = req_word_reg[LINE_ADDR_W-1:OFF_W];
    assign req_tag     = req_word_reg[WORD_W-1:LINE_ADDR_W];
    assign cnt_prev    = cnt_reg - CNT_ONE;
    assign cnt_lo      = cnt_reg[OFF_W-1:0];
    assign cnt_prev_lo = cnt_prev[OFF_W-1:0];
    assign lookup_hit  = tag_rd.valid && (tag_rd.entry.tag == req_tag);
    assign tag_rd_index = in_word[LINE_ADDR_W-1:OFF_W];

    // Cost and saturating totals for the result being issued.
    assign resp_hit   = (outcome_reg == OUT_HIT);
    assign out_load   = !out_valid_reg || !out_stall;
    assign hits_inc   = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
    assign misses_inc = (misses_reg == '1) ? misses_reg : misses_reg + 1'b1;
    assign cycles_sum = {1'b0, cycles_reg} + (TOTAL_W + 1)'(resp_cost);
    assign cycles_add = cycles_sum[TOTAL_W] ? '1 : cycles_sum[TOTAL_W-1:0];

    always_comb
    begin
        if (req_preload_reg)
        begin
            resp_cost = '0;
        end
        else if (resp_hit)
        begin
            resp_cost = COST_W'(hit_cost_reg);
        end
        else
        begin
            resp_cost = COST_W'(miss_penalty_reg);
        end
    end

    // Memory requests for each phase of an access.
    always_comb
    begin
        tag_wr     = '0;
        line_we    = 1'b0;
        line_waddr = {req_index, req_off};
        line_wdata = req_data_reg;
        line_raddr = in_word[LINE_ADDR_W-1:0];
        back_we    = 1'b0;
        back_waddr = req_word_reg;
        back_wdata = req_data_reg;
        back_raddr = {req_tag, req_index, cnt_lo};
        case (state_reg)
            S_CLEAR:
            begin
                back_we    = 1'b1;
                back_waddr = clr_cnt_reg;
                back_wdata = '0;
            end
            S_IDLE:
            begin
                if (in_accept && in_preload)
                begin
                    back_we    = 1'b1;
                    back_waddr = in_word;
                    back_wdata = write_data;
                end
            end
            S_LOOKUP:
            begin
                // A write hit stores the word and marks the line dirty.
                if (lookup_hit && req_write_reg)
                begin
                    line_we            = 1'b1;
                    tag_wr.en          = 1'b1;
                    tag_wr.index       = req_index;
                    tag_wr.entry.tag   = req_tag;
                    tag_wr.entry.dirty = 1'b1;
                end
            end
            S_WB:
            begin
                // Read a victim word, write the previous one to backing memory.
                line_raddr = {req_index, cnt_lo};
                if (cnt_reg != '0)
                begin
                    back_we    = 1'b1;
                    back_waddr = {old_tag_reg, req_index, cnt_prev_lo};
                    back_wdata = line_rdata;
                end
            end
            S_FILL:
            begin
                // Refill one word per cycle; a write miss merges its data.
                if (cnt_reg != '0)
                begin
                    line_we    = 1'b1;
                    line_waddr = {req_index, cnt_prev_lo};
                    if (req_write_reg && (cnt_prev_lo == req_off))
                    begin
                        line_wdata = req_data_reg;
                    end
                    else
                    begin
                        line_wdata = back_rdata;
                    end
                end
                if (cnt_reg == CNT_LAST)
                begin
                    tag_wr.en          = 1'b1;
                    tag_wr.index       = req_index;
                    tag_wr.entry.tag   = req_tag;
                    tag_wr.entry.dirty = req_write_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cost_reg     <= HIT_COST_RESET;
            miss_penalty_reg <= MISS_PENALTY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIT_COST:     hit_cost_reg     <= cfg_data[HIT_COST_W-1:0];
                CFG_MISS_PENALTY: miss_penalty_reg <= cfg_data[MISS_PEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer state, request hold registers, totals and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            cnt_reg         <= '0;
            req_word_reg    <= '0;
            req_data_reg    <= '0;
            req_write_reg   <= 1'b0;
            req_preload_reg <= 1'b0;
            old_tag_reg     <= '0;
            rdata_reg       <= '0;
            outcome_reg     <= OUT_HIT;
            hits_reg        <= '0;
            misses_reg      <= '0;
            cycles_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            out_hit_reg     <= 1'b0;
            out_outcome_reg <= OUT_HIT;
            out_cost_reg    <= '0;
        end
        else
        begin
            // The result register empties when its transaction is taken.
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        req_word_reg    <= in_word;
                        req_data_reg    <= write_data;
                        req_write_reg   <= (func == FUNC_WRITE);
                        req_preload_reg <= in_preload;
                        if (in_preload)
                        begin
                            outcome_reg <= OUT_PRELOAD;
                            state_reg   <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_LOOKUP;
                        end
                    end
                end
                S_LOOKUP:
                begin
                    cnt_reg     <= '0;
                    old_tag_reg <= tag_rd.entry.tag;
                    rdata_reg   <= line_rdata;
                    if (lookup_hit)
                    begin
                        outcome_reg <= OUT_HIT;
                        state_reg   <= S_RESP;
                    end
                    else if (!tag_rd.valid)
                    begin
                        outcome_reg <= OUT_COLD;
                        state_reg   <= S_FILL;
                    end
                    else if (tag_rd.entry.dirty)
                    begin
                        outcome_reg <= OUT_DIRTY;
                        state_reg   <= S_WB;
                    end
                    else
                    begin
                        outcome_reg <= OUT_CLEAN;
                        state_reg   <= S_FILL;
                    end
                end
                S_WB:
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_ONE;
                    end
                end
                S_FILL:
                begin
                    // Catch the requested word as it passes by.
                    if ((cnt_reg != '0) && (cnt_prev_lo == req_off))
                    begin
                        rdata_reg <= back_rdata;
                    end
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_ONE;
                    end
                end
                S_RESP:
                begin
                    if (out_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_outcome_reg <= outcome_reg;
                        out_cost_reg    <= resp_cost;
                        out_hit_reg     <= resp_hit && !req_preload_reg;
                        if (req_write_reg || req_preload_reg)
                        begin
                            out_data_reg <= '0;
                        end
                        else
                        begin
                            out_data_reg <= rdata_reg;
                        end
                        if (!req_preload_reg)
                        begin
                            cycles_reg <= cycles_add;
                            if (resp_hit)
                            begin
                                hits_reg <= hits_inc;
                            end
                            else
                            begin
                                misses_reg <= misses_inc;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_data_reg;
    assign hit           = out_hit_reg;
    assign outcome       = out_outcome_reg;
    assign access_cycles = out_cost_reg;
    assign hits_so_far   = hits_reg;
    assign misses_so_far = misses_reg;
    assign cycles_so_far = cycles_reg;

endmodule

### design/direct_mapped_writeback_cache_top.sv
// Top level of the direct-mapped write-back write-allocate cache with its backing memory.
//
// A direct-mapped, write-back, write-allocate cache of 128 lines of 16 words in front of
// a 64K-word backing memory that the block holds itself. One transaction is handled at a
// time and each gives one result. After reset the backing memory is zeroed by a clearing
// pass over all MEM_WORDS (65536) words during which no request is accepted; configuration
// writes are taken throughout. A hit passes through the lookup (tag and line read) and the
// result, a preload goes straight to the result, a cold or clean miss adds a refill and a
// dirty miss a victim writeback before the refill: each moves one word per cycle through
// the single write port of the backing or line memory, behind its registered read port.
// A result waiting in the output register does not hold up the next lookup.
module direct_mapped_writeback_cache_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dmc_pkg::FUNC_W-1:0]        func,
    input  logic [dmc_pkg::ADDR_W-1:0]        byte_address,
    input  logic [dmc_pkg::DATA_W-1:0]        write_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dmc_pkg::DATA_W-1:0]        read_data,
    output logic                              hit,
    output logic [dmc_pkg::OUTCOME_W-1:0]     outcome,
    output logic [dmc_pkg::COST_W-1:0]        access_cycles,
    output logic [dmc_pkg::TOTAL_W-1:0]       hits_so_far,
    output logic [dmc_pkg::TOTAL_W-1:0]       misses_so_far,
    output logic [dmc_pkg::TOTAL_W-1:0]       cycles_so_far
);
    import dmc_pkg::*;

    logic [IDX_W-1:0]       tag_rd_index;
    tag_wr_t                tag_wr;
    tag_rd_t                tag_rd;
    logic                   line_we;
    logic [LINE_ADDR_W-1:0] line_waddr;
    logic [DATA_W-1:0]      line_wdata;
    logic [LINE_ADDR_W-1:0] line_raddr;
    logic [DATA_W-1:0]      line_rdata;
    logic                   back_we;
    logic [WORD_W-1:0]      back_waddr;
    logic [DATA_W-1:0]      back_wdata;
    logic [WORD_W-1:0]      back_raddr;
    logic [DATA_W-1:0]      back_rdata;

    // Access sequencer.
    dmc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .byte_address  (byte_address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .hit           (hit),
        .outcome       (outcome),
        .access_cycles (access_cycles),
        .hits_so_far   (hits_so_far),
        .misses_so_far (misses_so_far),
        .cycles_so_far (cycles_so_far),
        .tag_rd_index  (tag_rd_index),
        .tag_wr        (tag_wr),
        .tag_rd        (tag_rd),
        .line_we       (line_we),
        .line_waddr    (line_waddr),
        .line_wdata    (line_wdata),
        .line_raddr    (line_raddr),
        .line_rdata    (line_rdata),
        .back_we       (back_we),
        .back_waddr    (back_waddr),
        .back_wdata    (back_wdata),
        .back_raddr    (back_raddr),
        .back_rdata    (back_rdata)
    );

    // Tags, dirty bits and valid bits.
    dmc_tag_store u_tags (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_index (tag_rd_index),
        .wr       (tag_wr),
        .rd       (tag_rd)
    );

    // Cached line words.
    dmc_ram #(
        .DEPTH (LINE_WORDS),
        .WIDTH (DATA_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Backing memory.
    dmc_ram #(
        .DEPTH (MEM_WORDS),
        .WIDTH (DATA_W)
    ) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

endmodule

### design/dmc_checker.sv
// Port-level assertions for the cache top level and the bind that attaches them.
module dmc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [dmc_pkg::DATA_W-1:0]        read_data,
    input  logic                              hit,
    input  logic [dmc_pkg::OUTCOME_W-1:0]     outcome,
    input  logic [dmc_pkg::COST_W-1:0]        access_cycles,
    input  logic [dmc_pkg::TOTAL_W-1:0]       hits_so_far,
    input  logic [dmc_pkg::TOTAL_W-1:0]       misses_so_far,
    input  logic [dmc_pkg::TOTAL_W-1:0]       cycles_so_far
);
    import dmc_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(outcome)
            && $stable(hits_so_far) && $stable(cycles_so_far))
        else $error("result payload changed while stalled");

    // Only one transaction is in flight: an accepted request closes the input.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in flight");

    // The hit flag and the outcome code agree.
    a_hit_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (outcome == OUT_HIT)))
        else $error("hit flag disagrees with outcome");

    // A preload reports no data and no cost.
    a_preload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_PRELOAD) |-> (read_data == '0) && (access_cycles == '0))
        else $error("preload result carries data or cost");

    // Running totals never decrease from one transaction to the next.
    a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 out_valid |->
            (hits_so_far >= $past(hits_so_far)) && (misses_so_far >= $past(misses_so_far))
            && (cycles_so_far >= $past(cycles_so_far)))
        else $error("running total decreased");

endmodule

bind direct_mapped_writeback_cache_top dmc_checker u_dmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .hit           (hit),
    .outcome       (outcome),
    .access_cycles (access_cycles),
    .hits_so_far   (hits_so_far),
    .misses_so_far (misses_so_far),
    .cycles_so_far (cycles_so_far)
);

### verif/direct_mapped_writeback_cache_top_test.sv
// Self-checking testbench for the direct-mapped write-back cache top level.
module direct_mapped_writeback_cache_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmc_pkg::*;

    // Function codes that the package does not name.
    localparam logic [FUNC_W-1:0] FUNC_READ        = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_PRELOAD     = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_PRELOAD_ALT = FUNC_W'(3);

    localparam int MAX_GAP        = 18;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 200000;

    // One expected cache response.
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               hit_flag;
        outcome_t           outcome;
        logic [COST_W-1:0]  cost;
        logic [TOTAL_W-1:0] hits;
        logic [TOTAL_W-1:0] misses;
        logic [TOTAL_W-1:0] cycles;
    } cache_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func = '0;
    logic [ADDR_W-1:0]     byte_address = '0;
    logic [DATA_W-1:0]     write_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DATA_W-1:0]     read_data;
    logic                  hit;
    logic [OUTCOME_W-1:0]  outcome;
    logic [COST_W-1:0]     access_cycles;
    logic [TOTAL_W-1:0]    hits_so_far;
    logic [TOTAL_W-1:0]    misses_so_far;
    logic [TOTAL_W-1:0]    cycles_so_far;

    // Shadow copy of the cache, the backing memory and the running totals.
    logic [TAG_W-1:0]      tag_model [NUM_LINES];
    logic                  valid_model [NUM_LINES];
    logic                  dirty_model [NUM_LINES];
    logic [DATA_W-1:0]     line_model [LINE_WORDS];
    logic [DATA_W-1:0]     backing_model [MEM_WORDS];
    logic [TOTAL_W-1:0]    hit_total;
    logic [TOTAL_W-1:0]    miss_total;
    logic [TOTAL_W-1:0]    cycle_total;
    logic [HIT_COST_W-1:0] model_hit_cost;
    logic [MISS_PEN_W-1:0] model_miss_penalty;

    cache_result_t expected_results [$];
    int            mismatch_count;
    bit            sender_idles;
    bit            receiver_idles;
    bit            hold_output_requested;

    direct_mapped_writeback_cache_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .byte_address  (byte_address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .hit           (hit),
        .outcome       (outcome),
        .access_cycles (access_cycles),
        .hits_so_far   (hits_so_far),
        .misses_so_far (misses_so_far),
        .cycles_so_far (cycles_so_far)
    );

    // Clock generation.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Shadow state starts out as the block does after reset.
    initial
    begin
        for (int n = 0; n < NUM_LINES; n++)
        begin
            tag_model[n] = '0;
            valid_model[n] = 1'b0;
            dirty_model[n] = 1'b0;
        end
        for (int n = 0; n < LINE_WORDS; n++)
        begin
            line_model[n] = '0;
        end
        for (int n = 0; n < MEM_WORDS; n++)
        begin
            backing_model[n] = '0;
        end
        hit_total = '0;
        miss_total = '0;
        cycle_total = '0;
        model_hit_cost = HIT_COST_RESET;
        model_miss_penalty = MISS_PENALTY_RESET;
    end

    function automatic logic [TOTAL_W-1:0] add_saturating(logic [TOTAL_W-1:0] a,
                                                          logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    endfunction

    // Compute the response to one accepted access and queue it.
    function automatic void predict_access(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                           logic [DATA_W-1:0] d);
        cache_result_t      r;
        logic [WORD_W-1:0]  word;
        logic [TAG_W-1:0]   tg;
        logic [IDX_W-1:0]   idx;
        logic [OFF_W-1:0]   off;
        word = a[ADDR_W-1:2];
        {tg, idx, off} = word;
        r = '0;
        if (f[PRELOAD_BIT])
        begin
            // A preload touches only the backing memory.
            backing_model[word] = d;
            r.outcome = OUT_PRELOAD;
        end
        else
        begin
            if (valid_model[idx] && tag_model[idx] == tg)
            begin
                r.hit_flag = 1'b1;
                r.outcome = OUT_HIT;
                r.cost = COST_W'(model_hit_cost);
                hit_total = add_saturating(hit_total, 1);
            end
            else
            begin
                // Classify the miss and write back a dirty victim first.
                if (!valid_model[idx])
                begin
                    r.outcome = OUT_COLD;
                end
                else if (dirty_model[idx])
                begin
                    r.outcome = OUT_DIRTY;
                    for (int n = 0; n < WORDS_PER_LINE; n++)
                    begin
                        backing_model[{tag_model[idx], idx, OFF_W'(n)}] =
                            line_model[{idx, OFF_W'(n)}];
                    end
                end
                else
                begin
                    r.outcome = OUT_CLEAN;
                end
                for (int n = 0; n < WORDS_PER_LINE; n++)
                begin
                    line_model[{idx, OFF_W'(n)}] = backing_model[{tg, idx, OFF_W'(n)}];
                end
                valid_model[idx] = 1'b1;
                tag_model[idx] = tg;
                dirty_model[idx] = 1'b0;
                r.cost = COST_W'(model_miss_penalty);
                miss_total = add_saturating(miss_total, 1);
            end
            cycle_total = add_saturating(cycle_total, TOTAL_W'(r.cost));
            if (f == FUNC_WRITE)
            begin
                line_model[{idx, off}] = d;
                dirty_model[idx] = 1'b1;
            end
            else
            begin
                r.read_data = line_model[{idx, off}];
            end
        end
        r.hits = hit_total;
        r.misses = miss_total;
        r.cycles = cycle_total;
        expected_results.push_back(r);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endfunction

    // Write one configuration register while the cache is idle.
    task automatic write_register(cfg_index_t register_sel, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= register_sel;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (register_sel)
            CFG_HIT_COST:     model_hit_cost = value[HIT_COST_W-1:0];
            CFG_MISS_PENALTY: model_miss_penalty = value[MISS_PEN_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one transaction, after a random gap when the sender idles, and wait until it is taken.
    task automatic send_request(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                logic [DATA_W-1:0] d);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        byte_address <= a;
        write_data <= d;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        predict_access(f, a, d);
    endtask

    // Let every outstanding response drain before touching the registers.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random traffic leans on a few lines so that hits and conflicts are common.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [TAG_W-1:0] tg;
        logic [IDX_W-1:0] idx;
        if ($urandom_range(0, 4) == 0)
        begin
            return ADDR_W'($urandom);
        end
        tg = $urandom_range(0, 1) ? TAG_W'($urandom_range(0, 2)) : TAG_W'($urandom_range(29, 31));
        idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 5))
                                   : IDX_W'($urandom_range(122, 127));
        return {tg, idx, OFF_W'($urandom), 2'($urandom)};
    endfunction

    function automatic logic [FUNC_W-1:0] pick_function();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return FUNC_READ;
        else if (roll < 85)
            return FUNC_WRITE;
        else if (roll < 93)
            return FUNC_PRELOAD;
        else
            return FUNC_PRELOAD_ALT;
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else
            return $urandom;
    endfunction

    task automatic run_random_traffic(int count);
        for (int n = 0; n < count; n++)
        begin
            // Change the idling pattern now and then, sometimes switching it off.
            if (n % 60 == 0)
            begin
                sender_idles = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            send_request(pick_function(), pick_address(), pick_data());
        end
    endtask

    // Hand-picked accesses at the reset costs: every outcome and the corner cases.
    task automatic test_directed_accesses();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        send_request(FUNC_READ, 18'h00000, 32'h0);                  // cold miss on line 0
        send_request(FUNC_PRELOAD, 18'h00040, 32'hFFFF_FFFF);       // preload, not cached
        send_request(FUNC_PRELOAD_ALT, 18'h00044, 32'hA5A5_A5A5);   // unused code acts as preload
        send_request(FUNC_READ, 18'h00040, 32'h0);                  // cold miss sees preloads
        send_request(FUNC_READ, 18'h00045, 32'h0);                  // hit, low bits ignored
        send_request(FUNC_PRELOAD, 18'h00048, 32'h1234_5678);       // preload of a cached line
        send_request(FUNC_READ, 18'h0004A, 32'h0);                  // hit keeps the stale copy
        send_request(FUNC_WRITE, 18'h0004C, 32'hDEAD_BEEF);         // write hit makes it dirty
        send_request(FUNC_READ, 18'h0004C, 32'h0);
        send_request(FUNC_READ, 18'h02040, 32'h0);                  // dirty conflict
        send_request(FUNC_READ, 18'h00048, 32'h0);                  // clean conflict
        send_request(FUNC_WRITE, 18'h3FFFC, 32'h8000_0001);         // write miss, top address
        send_request(FUNC_READ, 18'h3FFFF, 32'h0);
        send_request(FUNC_READ, 18'h01FC0, 32'h0);                  // dirty conflict on last line
        send_request(FUNC_READ, 18'h3FFFE, 32'h0);                  // read refill left it clean
        send_request(FUNC_WRITE, 18'h00000, 32'hFFFF_FFFF);
        send_request(FUNC_WRITE, 18'h3E000, 32'h0000_0000);         // write miss over dirty line
        send_request(FUNC_READ, 18'h00003, 32'h0);
        wait_for_idle();
    endtask

    // Both costs at their lowest; the upper bits of the hit cost write are dropped.
    task automatic test_zero_cost_traffic();
        write_register(CFG_HIT_COST, 16'hFF00);
        write_register(CFG_MISS_PENALTY, 16'h0000);
        run_random_traffic(420);
        wait_for_idle();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        hold_output_requested = 1'b1;
        for (int n = 0; n < 40; n++)
        begin
            send_request(pick_function(), pick_address(), pick_data());
        end
        wait_for_idle();
    endtask

    task automatic test_max_cost_traffic();
        write_register(CFG_HIT_COST, 16'h00FF);
        write_register(CFG_MISS_PENALTY, 16'hFFFF);
        run_random_traffic(420);
        wait_for_idle();
    endtask

    task automatic test_mid_cost_traffic();
        write_register(CFG_HIT_COST, 16'hA525);
        write_register(CFG_MISS_PENALTY, CFG_DATA_W'($urandom_range(1, 65534)));
        run_random_traffic(420);
        wait_for_idle();
    endtask

    // Response side: random stalls, the long hold when asked, and the checks.
    initial
    begin
        int stall_cycles;
        cache_result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall_cycles = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_output_requested)
            begin
                stall_cycles = HOLD_CYCLES;
                hold_output_requested = 1'b0;
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1);
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected response: outcome %h, read data %h", outcome, read_data);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("read_data", want.read_data, read_data);
                compare_field("hit", 32'(want.hit_flag), 32'(hit));
                compare_field("outcome", 32'(want.outcome), 32'(outcome));
                compare_field("access_cycles", 32'(want.cost), 32'(access_cycles));
                compare_field("hits_so_far", want.hits, hits_so_far);
                compare_field("misses_so_far", want.misses, misses_so_far);
                compare_field("cycles_so_far", want.cycles, cycles_so_far);
            end
        end
    end

    // Watchdog: give up after too long without any transaction on either side.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[direct_mapped_writeback_cache_top] ERROR");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        mismatch_count = 0;
        hold_output_requested = 1'b0;
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_accesses();
        test_zero_cost_traffic();
        test_output_backpressure();
        test_max_cost_traffic();
        test_mid_cost_traffic();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[direct_mapped_writeback_cache_top] OK");
        else
            $display("[direct_mapped_writeback_cache_top] ERROR");
        $finish;
    end

endmodule

### files.f
design/dmc_pkg.sv
design/dmc_ram.sv
design/dmc_tag_store.sv
design/dmc_ctrl.sv
design/direct_mapped_writeback_cache_top.sv
design/dmc_checker.sv
verif/direct_mapped_writeback_cache_top_test.sv
